// File: design/ctb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ctb_pkg;

	localparam int NUM_TIMERS_DEF    = 8;
	localparam int MASTER_WRAP_LIMIT = 20000;
	localparam int SNAP_W            = 32;

	typedef enum logic [1:0] {
		KIND_TICK         = 2'd0,
		KIND_START        = 2'd1,
		KIND_READ         = 2'd2,
		KIND_READ_RESTART = 2'd3
	} ctb_kind_t;

	typedef enum logic [1:0] {
		MODE_16M = 2'd0,
		MODE_8M  = 2'd1,
		MODE_1M  = 2'd2
	} ctb_mode_t;

	typedef struct packed {
		ctb_kind_t   kind;
		logic [2:0]  timer_index;
	} ctb_req_t;

	typedef struct packed {
		logic signed [31:0] ticks;
		logic signed [31:0] milliseconds;
		logic signed [31:0] microseconds;
		logic        [31:0] uptime_ms;
	} ctb_result_t;

	// live view of the shared counters
	typedef struct packed {
		logic [31:0] now;
		logic [31:0] master_ticks;
		logic [15:0] epochs;
	} ctb_time_t;

endpackage
`default_nettype wire

// File: design/ctb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ctb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first: a read and a write to one address in a cycle returns the old word
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: design/ctb_cnt.sv
`timescale 1ns / 1ps
`default_nettype none
module ctb_cnt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick,
	input  wire logic              master_restart,
	output      ctb_pkg::ctb_time_t tm
);
	import ctb_pkg::*;

	logic [15:0] count_q;
	logic [15:0] wrap_q;
	logic [14:0] master_wraps_q;
	logic [15:0] master_start_q;
	logic [15:0] epochs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			wrap_q         <= '0;
			master_wraps_q <= '0;
			master_start_q <= '0;
			epochs_q       <= '0;
		end else if (tick) begin
			count_q <= count_q + 16'd1;
			if (count_q == 16'hFFFF) begin
				wrap_q <= wrap_q + 16'd1;
				if (master_wraps_q == 15'(MASTER_WRAP_LIMIT - 1)) begin
					master_wraps_q <= '0;
					epochs_q       <= epochs_q + 16'd1;
				end else begin
					master_wraps_q <= master_wraps_q + 15'd1;
				end
			end
		end else if (master_restart) begin
			master_wraps_q <= '0;
			master_start_q <= count_q;
		end
	end

	assign tm.now          = {wrap_q, count_q};
	assign tm.master_ticks = {1'b0, master_wraps_q, count_q} - {16'd0, master_start_q};
	assign tm.epochs       = epochs_q;

endmodule
`default_nettype wire

// File: design/ctb_rd.sv
`timescale 1ns / 1ps
`default_nettype none
module ctb_rd (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic                 is_master,
	input  wire logic [1:0]           mode,
	input  wire ctb_pkg::ctb_time_t   tm,
	input  wire logic                 snap_valid,
	input  wire logic [31:0]          snap_rdata,
	output      logic                 result_valid,
	output      ctb_pkg::ctb_result_t result
);
	import ctb_pkg::*;

	localparam logic [7:0] EPOCH_K_16M = 8'd10;
	localparam logic [7:0] EPOCH_K_8M  = 8'd20;
	localparam logic [7:0] EPOCH_K_1M  = 8'd160;

	logic        go_s1;
	logic        master_s1;
	logic [1:0]  mode_s1;
	ctb_time_t   tm_s1;
	logic        snap_valid_s1;

	logic              valid_q;
	ctb_result_t       result_q;

	logic [31:0]        snap;
	logic signed [31:0] ticks;
	logic signed [31:0] ms;
	logic signed [31:0] us;
	logic signed [31:0] mt_shift;
	logic [7:0]         epoch_k;
	logic [15:0]        epoch_prod;
	logic [31:0]        uptime;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			master_s1     <= is_master;
			mode_s1       <= mode;
			tm_s1         <= tm;
			snap_valid_s1 <= snap_valid;
		end
	end

	// entry never written reads as zero
	assign snap  = snap_valid_s1 ? snap_rdata : 32'd0;
	assign ticks = master_s1 ? $signed(tm_s1.master_ticks) : $signed(tm_s1.now - snap);

	always_comb begin
		unique case (mode_s1)
			MODE_16M: begin
				ms       = ticks >>> 11;
				us       = ticks >>> 1;
				mt_shift = $signed(tm_s1.master_ticks) >>> 11;
				epoch_k  = EPOCH_K_16M;
			end
			MODE_8M: begin
				ms       = ticks >>> 10;
				us       = ticks;
				mt_shift = $signed(tm_s1.master_ticks) >>> 10;
				epoch_k  = EPOCH_K_8M;
			end
			default: begin
				ms       = ticks >>> 7;
				us       = ticks <<< 2;
				mt_shift = $signed(tm_s1.master_ticks) >>> 7;
				epoch_k  = EPOCH_K_1M;
			end
		endcase
	end

	// every scale is a small factor times 2^16
	assign epoch_prod = 16'(tm_s1.epochs * epoch_k);
	assign uptime     = {epoch_prod, 16'd0} + $unsigned(mt_shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			result_q.ticks        <= ticks;
			result_q.milliseconds <= ms;
			result_q.microseconds <= us;
			result_q.uptime_ms    <= uptime;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// File: design/cascaded_multi_timer_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// a read request's result strobe is registered in go_s1 and then in valid_q after acceptance
// throughput: one request per cycle, busy never rises; ticks may come every cycle
// the receiver cannot stall, so each result is shown for exactly one cycle
// reset (arst_n low, asynchronous) clears the counters, the clock mode and the
// per-timer valid bits, so every start snapshot reads as zero until written
module cascaded_multi_timer_bank #(
	parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_wdata,
	input  wire logic                 start,
	output      logic                 busy,
	input  wire ctb_pkg::ctb_req_t    req,
	output      logic                 result_valid,
	output      ctb_pkg::ctb_result_t result
);
	import ctb_pkg::*;

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	logic [1:0]            mode_q;
	logic [NUM_TIMERS-1:0] snap_vld_q;

	logic          accept;
	logic          idx_ok;
	logic          is_master;
	logic          is_read;
	logic          is_restart;
	logic          snap_we;
	logic          master_restart;
	logic [AW-1:0] addr;
	logic [31:0]   snap_rdata;
	ctb_time_t     tm;

	// every request is taken in the cycle it arrives
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// indexes beyond the bank are dropped without a result
	assign idx_ok     = 32'(req.timer_index) < NUM_TIMERS;
	assign addr       = AW'(req.timer_index);
	assign is_master  = req.timer_index == 3'd0;
	assign is_read    = accept && idx_ok &&
		(req.kind == KIND_READ || req.kind == KIND_READ_RESTART);
	assign is_restart = accept && idx_ok &&
		(req.kind == KIND_START || req.kind == KIND_READ_RESTART);

	// the restart write lands in the same cycle as the read; the ram is read-first,
	// so the result still sees the old snapshot and any later read sees the new one
	assign snap_we        = is_restart && !is_master;
	assign master_restart = is_restart && is_master;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_16M;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_vld_q <= '0;
		end else if (snap_we) begin
			snap_vld_q[addr] <= 1'b1;
		end
	end

	// shared prescaled counter, wrap count, master wraps and epochs
	ctb_cnt u_cnt (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (accept && req.kind == KIND_TICK),
		.master_restart (master_restart),
		.tm             (tm)
	);

	// start snapshots of the non-master timers
	ctb_ram #(
		.WIDTH (SNAP_W),
		.DEPTH (NUM_TIMERS)
	) u_snap_ram (
		.clk   (clk),
		.we    (snap_we),
		.waddr (addr),
		.wdata (tm.now),
		.re    (is_read),
		.raddr (addr),
		.rdata (snap_rdata)
	);

	// elapsed time, scaling and uptime, then the output register
	ctb_rd u_rd (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (is_read),
		.is_master    (is_master),
		.mode         (mode_q),
		.tm           (tm),
		.snap_valid   (snap_vld_q[addr]),
		.snap_rdata   (snap_rdata),
		.result_valid (result_valid),
		.result       (result)
	);

	// a result strobe only ever follows a read request, through the go_s1 and valid_q registers
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(is_read, 2))
		else $error("result strobe without a read request");

	// a tick request never produces a result
	a_tick_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == KIND_TICK) |=> ##1 !result_valid)
		else $error("tick request produced a result");

	// restarting the master zeroes its elapsed count
	a_master_restart: assert property (@(posedge clk) disable iff (!arst_n)
		master_restart |=> tm.master_ticks == 32'd0)
		else $error("master restart did not clear elapsed ticks");

endmodule
`default_nettype wire

// File: dv/ctb_result_checker.sv
`timescale 1ns / 1ps
module ctb_result_checker #(
	parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	input  logic                 start,
	input  logic                 busy,
	input  ctb_pkg::ctb_req_t    req,
	input  logic                 result_valid,
	input  ctb_pkg::ctb_result_t result,
	output int                   fail_count,
	output int                   pending
);
	import ctb_pkg::*;

	localparam int          MS_SHIFT_16M = 11;
	localparam int          MS_SHIFT_8M  = 10;
	localparam int          MS_SHIFT_1M  = 7;
	localparam logic [31:0] EPOCH_MS_16M = 32'd655360;
	localparam logic [31:0] EPOCH_MS_8M  = 32'd1310720;
	localparam logic [31:0] EPOCH_MS_1M  = 32'd10485760;
	localparam int          REPORT_LIMIT = 10;

	logic [1:0]  clock_mode;
	logic [15:0] prescaled;
	logic [15:0] wraps;
	logic [31:0] snapshot [NUM_TIMERS];
	logic [14:0] master_wraps;
	logic [15:0] master_start_low;
	logic [15:0] epochs;

	ctb_result_t expected_results [$];
	int          failures = 0;
	int          outstanding = 0;

	assign fail_count = failures;
	assign pending    = outstanding;

	function automatic logic [31:0] master_elapsed();
		return {1'b0, master_wraps, prescaled} - {16'h0, master_start_low};
	endfunction

	task automatic clear_timebase();
		clock_mode       = MODE_16M;
		prescaled        = '0;
		wraps            = '0;
		master_wraps     = '0;
		master_start_low = '0;
		epochs           = '0;
		for (int i = 0; i < NUM_TIMERS; i++)
			snapshot[i] = '0;
	endtask

	task automatic advance_tick();
		prescaled = prescaled + 16'd1;
		if (prescaled == 16'd0) begin
			wraps = wraps + 16'd1;
			if (int'(master_wraps) + 1 >= MASTER_WRAP_LIMIT) begin
				master_wraps = '0;
				epochs       = epochs + 16'd1;
			end else begin
				master_wraps = master_wraps + 15'd1;
			end
		end
	endtask

	task automatic restart_timer(input logic [2:0] idx);
		if (idx == 3'd0) begin
			master_wraps     = '0;
			master_start_low = prescaled;
		end else begin
			snapshot[idx] = {wraps, prescaled};
		end
	endtask

	task automatic apply_request(input ctb_req_t r);
		ctb_mode_t   eff_mode;
		int          shift;
		logic [31:0] scale;
		logic [31:0] elapsed;
		logic [31:0] master_ms;
		ctb_result_t res;
		if (r.kind == KIND_TICK) begin
			advance_tick();
		end else if (int'(r.timer_index) < NUM_TIMERS) begin
			if (r.kind == KIND_START) begin
				restart_timer(r.timer_index);
			end else begin
				// the spare mode code behaves as the 1 MHz one
				eff_mode = (clock_mode == MODE_16M) ? MODE_16M :
					(clock_mode == MODE_8M) ? MODE_8M : MODE_1M;
				case (eff_mode)
					MODE_16M: begin
						shift = MS_SHIFT_16M;
						scale = EPOCH_MS_16M;
					end
					MODE_8M: begin
						shift = MS_SHIFT_8M;
						scale = EPOCH_MS_8M;
					end
					default: begin
						shift = MS_SHIFT_1M;
						scale = EPOCH_MS_1M;
					end
				endcase
				if (r.timer_index == 3'd0)
					elapsed = master_elapsed();
				else
					elapsed = {wraps, prescaled} - snapshot[r.timer_index];
				res.ticks        = elapsed;
				res.milliseconds = $signed(elapsed) >>> shift;
				case (eff_mode)
					MODE_16M: res.microseconds = $signed(elapsed) >>> 1;
					MODE_8M:  res.microseconds = elapsed;
					default:  res.microseconds = elapsed << 2;
				endcase
				master_ms     = $signed(master_elapsed()) >>> shift;
				res.uptime_ms = {16'h0, epochs} * scale + master_ms;
				expected_results.push_back(res);
				// uptime and elapsed are taken before the timer restarts
				if (r.kind == KIND_READ_RESTART)
					restart_timer(r.timer_index);
			end
		end
	endtask

	initial clear_timebase();

	always @(posedge clk or negedge arst_n) begin
		ctb_result_t want;
		if (!arst_n) begin
			clear_timebase();
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("%0t: result with nothing outstanding: %h", $realtime, result);
				end else begin
					want = expected_results.pop_front();
					if (want.ticks !== result.ticks || want.milliseconds !== result.milliseconds ||
						want.microseconds !== result.microseconds ||
						want.uptime_ms !== result.uptime_ms) begin
						failures++;
						if (failures <= REPORT_LIMIT)
							$display("%0t: mismatch ticks %h/%h ms %h/%h us %h/%h up %h/%h (exp/act)",
								$realtime, want.ticks, result.ticks, want.milliseconds,
								result.milliseconds, want.microseconds, result.microseconds,
								want.uptime_ms, result.uptime_ms);
					end
				end
			end
			if (cfg_we)
				clock_mode = cfg_wdata;
			if (start && !busy)
				apply_request(req);
			outstanding = expected_results.size();
		end
	end

endmodule

// File: dv/tb_cascaded_multi_timer_bank.sv
`timescale 1ns / 1ps
module tb_cascaded_multi_timer_bank;
	import ctb_pkg::*;

	// the fourth mode code is unused by the block and must act as 1 MHz
	localparam logic [1:0] MODE_SPARE       = 2'd3;
	localparam int         NUM_PHASES       = 5;
	localparam int         RANDOM_PER_PHASE = 346;
	localparam int         SETTLE_CYCLES    = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_wdata = 2'd0;
	logic        start     = 1'b0;
	logic        busy;
	ctb_req_t    req       = '0;
	logic        result_valid;
	ctb_result_t result;
	int          fail_count;
	int          pending;
	int          burst_left = 0;

	cascaded_multi_timer_bank u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.result       (result)
	);

	// watches both channels, predicts every read and scores the results
	ctb_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// generous ceiling: the slowest correct run is well under a millisecond
	initial begin
		#10_000_000;
		$display("tb_cascaded_multi_timer_bank failed");
		$finish;
	end

	// present one request from the falling edge and hold it until accepted;
	// busy is stable from the falling edge to the next rising one
	task automatic issue(input ctb_kind_t kind, input logic [2:0] idx);
		logic accept;
		@(negedge clk);
		start           <= 1'b1;
		req.kind        <= kind;
		req.timer_index <= idx;
		forever begin
			accept = !busy;
			@(posedge clk);
			if (accept)
				break;
			@(negedge clk);
		end
	endtask

	// sender idles in bursts: random burst length, random gap between bursts,
	// and a gap of zero now and then so some bursts run back to back
	task automatic paced_issue(input ctb_kind_t kind, input logic [2:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		issue(kind, idx);
	endtask

	// hold off until every read has come back, then let the pipe settle
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mode changes only ever happen with the bank idle
	task automatic write_clock_mode(input logic [1:0] mode);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// half of them ticks so the counters move, the rest starts and reads on any timer
	task automatic random_request();
		int        pick;
		ctb_kind_t kind;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			kind = KIND_TICK;
		else if (pick < 65)
			kind = KIND_START;
		else if (pick < 85)
			kind = KIND_READ;
		else
			kind = KIND_READ_RESTART;
		paced_issue(kind, 3'($urandom_range(0, 7)));
	endtask

	initial begin
		logic [1:0] phase_mode [NUM_PHASES];
		int         waited;
		// reset mode first, then the spare code, both others, and back to 16 MHz
		phase_mode = '{MODE_16M, MODE_SPARE, MODE_8M, MODE_1M, MODE_16M};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed opening: reads straight after reset, master and highest timer,
		// read and restart against plain read, a timer that was never started
		issue(KIND_READ, 3'd0);
		issue(KIND_READ, 3'd7);
		issue(KIND_START, 3'd0);
		issue(KIND_START, 3'd7);
		issue(KIND_TICK, 3'd7);
		issue(KIND_TICK, 3'd0);
		issue(KIND_TICK, 3'd5);
		issue(KIND_READ, 3'd0);
		issue(KIND_READ, 3'd7);
		issue(KIND_READ_RESTART, 3'd0);
		issue(KIND_READ, 3'd0);
		issue(KIND_READ_RESTART, 3'd7);
		issue(KIND_READ, 3'd7);
		issue(KIND_START, 3'd3);
		issue(KIND_TICK, 3'd2);
		issue(KIND_READ, 3'd3);
		issue(KIND_READ, 3'd5);
		issue(KIND_READ_RESTART, 3'd4);
		issue(KIND_TICK, 3'd1);
		issue(KIND_READ, 3'd4);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0)
				write_clock_mode(phase_mode[p]);
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				// occasional full stop with every result back before carrying on
				if ($urandom_range(0, 49) == 0)
					drain_results();
				random_request();
			end
		end

		// wind down: lower start, wait for stragglers with a bound, then settle
		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 1000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("tb_cascaded_multi_timer_bank passed");
		else
			$display("tb_cascaded_multi_timer_bank failed");
		$finish;
	end

endmodule
